// ===== rtl/kl_pkg.sv =====
// kl_pkg: shared types, token codes and lookup functions for the keyword lexer
`timescale 1ns / 1ps
`default_nettype none

package kl_pkg;

  // longest identifier accepted, 1 to 8
  localparam int unsigned IDENT_MAX = 8;

  // most tokens one source byte can produce
  localparam int unsigned MAX_RES = 3;

  localparam logic [30:0] INT_SAT  = 31'h7FFF_FFFF;
  localparam logic [15:0] LINE_SAT = 16'hFFFF;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // token kinds
  localparam logic [4:0] K_EXIT     = 5'd0;
  localparam logic [4:0] K_LET      = 5'd1;
  localparam logic [4:0] K_CONST    = 5'd2;
  localparam logic [4:0] K_IF       = 5'd3;
  localparam logic [4:0] K_ELIF     = 5'd4;
  localparam logic [4:0] K_ELSE     = 5'd5;
  localparam logic [4:0] K_IDENT    = 5'd6;
  localparam logic [4:0] K_INT      = 5'd7;
  localparam logic [4:0] K_LPAREN   = 5'd8;
  localparam logic [4:0] K_RPAREN   = 5'd9;
  localparam logic [4:0] K_EQUAL    = 5'd10;
  localparam logic [4:0] K_PLUS     = 5'd11;
  localparam logic [4:0] K_MINUS    = 5'd12;
  localparam logic [4:0] K_STAR     = 5'd13;
  localparam logic [4:0] K_SLASH    = 5'd14;
  localparam logic [4:0] K_LBRACE   = 5'd15;
  localparam logic [4:0] K_RBRACE   = 5'd16;
  localparam logic [4:0] K_SEMI     = 5'd17;
  localparam logic [4:0] K_END      = 5'd18;
  localparam logic [4:0] K_ERR_BYTE = 5'd19;
  localparam logic [4:0] K_ERR_LONG = 5'd20;
  localparam logic [4:0] K_ERR_OPEN = 5'd21;

  // keyword spellings, first character in the lowest byte
  localparam logic [63:0] KW_EXIT  = 64'h0000_0000_7469_7865;
  localparam logic [63:0] KW_LET   = 64'h0000_0000_0074_656C;
  localparam logic [63:0] KW_CONST = 64'h0000_0074_736E_6F63;
  localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_ELIF  = 64'h0000_0000_6669_6C65;
  localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6C65;

  typedef enum logic [2:0] {
    M_IDLE     = 3'd0,
    M_IDENT    = 3'd1,
    M_NUMBER   = 3'd2,
    M_SLASH    = 3'd3,
    M_LCOMMENT = 3'd4,
    M_BLOCK    = 3'd5,
    M_BSTAR    = 3'd6,
    M_HALT     = 3'd7
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t   mode;
    logic [63:0] word;
    logic [3:0]  word_len;
    logic [30:0] accum;
    logic [15:0] line;
  } lex_state_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [30:0] ival;
    logic [63:0] chars;
    logic [3:0]  len;
    logic        last;
  } res_t;

  // plain token with no payload
  function automatic res_t mk_res(input logic [4:0] kind, input logic [15:0] line);
    res_t r;
    r      = '0;
    r.kind = kind;
    r.line = line;
    return r;
  endfunction

  // identifier or keyword from the collected word
  function automatic res_t word_res(input logic [63:0] word, input logic [3:0] len,
                                    input logic [15:0] line);
    res_t r;
    r = mk_res(K_IDENT, line);
    if (len == 4'd4 && word == KW_EXIT) begin
      r.kind = K_EXIT;
    end else if (len == 4'd3 && word == KW_LET) begin
      r.kind = K_LET;
    end else if (len == 4'd5 && word == KW_CONST) begin
      r.kind = K_CONST;
    end else if (len == 4'd2 && word == KW_IF) begin
      r.kind = K_IF;
    end else if (len == 4'd4 && word == KW_ELIF) begin
      r.kind = K_ELIF;
    end else if (len == 4'd4 && word == KW_ELSE) begin
      r.kind = K_ELSE;
    end else begin
      r.chars = word;
      r.len   = len;
    end
    return r;
  endfunction

  // single-byte punctuation: valid bit over the token kind
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] p;
    p = '0;
    unique case (c)
      CH_LPAREN: p = {1'b1, K_LPAREN};
      CH_RPAREN: p = {1'b1, K_RPAREN};
      CH_EQUAL:  p = {1'b1, K_EQUAL};
      CH_PLUS:   p = {1'b1, K_PLUS};
      CH_MINUS:  p = {1'b1, K_MINUS};
      CH_STAR:   p = {1'b1, K_STAR};
      CH_LBRACE: p = {1'b1, K_LBRACE};
      CH_RBRACE: p = {1'b1, K_RBRACE};
      CH_SEMI:   p = {1'b1, K_SEMI};
      default:   p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kl_step.sv =====
// kl_step: lexer next state and the tokens caused by one source byte
`timescale 1ns / 1ps
`default_nettype none

module kl_step (
  input  wire kl_pkg::lex_state_t                   st_i,
  input  wire logic [7:0]                           char_i,
  input  wire logic                                 last_i,
  output kl_pkg::lex_state_t                        st_o,
  output kl_pkg::res_t [kl_pkg::MAX_RES-1:0]        res_o,
  output logic [1:0]                                cnt_o
);

  logic              is_alpha;
  logic              is_digit;
  logic              is_alnum;
  logic              is_ws;
  logic              is_nl;
  logic [5:0]        punct;
  logic [7:0]        dig_full;
  logic [34:0]       acc_wide;
  logic [15:0]       line_after;
  logic              idle_path;
  kl_pkg::lex_state_t st_p;
  kl_pkg::res_t      cand [4];
  logic [3:0]        cand_v;
  logic [2:0]        n;
  logic [1:0]        last_idx;

  // byte classes
  assign is_alpha = (char_i >= kl_pkg::CH_LC_A && char_i <= kl_pkg::CH_LC_Z) ||
                    (char_i >= kl_pkg::CH_UC_A && char_i <= kl_pkg::CH_UC_Z);
  assign is_digit = char_i >= kl_pkg::CH_ZERO && char_i <= kl_pkg::CH_NINE;
  assign is_alnum = is_alpha || is_digit;
  assign is_nl    = char_i == kl_pkg::CH_NL;
  assign is_ws    = char_i == kl_pkg::CH_SPACE || char_i == kl_pkg::CH_TAB ||
                    char_i == kl_pkg::CH_VT || char_i == kl_pkg::CH_FF ||
                    char_i == kl_pkg::CH_CR;
  assign punct    = kl_pkg::punct_kind(char_i);
  assign dig_full = char_i - kl_pkg::CH_ZERO;

  // accum * 10 + digit, checked against the saturation limit
  assign acc_wide = ({4'b0, st_i.accum} << 3) + ({4'b0, st_i.accum} << 1) +
                    {31'b0, dig_full[3:0]};

  // every mode but halt counts a newline
  assign line_after = (is_nl && st_i.mode != kl_pkg::M_HALT && st_i.line != kl_pkg::LINE_SAT)
                      ? st_i.line + 16'd1 : st_i.line;

  // byte processing, end of text and result packing
  always_comb begin
    st_p      = st_i;
    st_p.line = line_after;
    idle_path = 1'b0;
    cand_v    = '0;
    for (int k = 0; k < 4; k++) begin
      cand[k] = '0;
    end

    // pending token extended or closed by this byte, comment and halt modes
    unique case (st_i.mode)
      kl_pkg::M_IDLE: begin
        idle_path = 1'b1;
      end
      kl_pkg::M_IDENT: begin
        if (is_alnum) begin
          if (st_i.word_len >= 4'(kl_pkg::IDENT_MAX)) begin
            cand_v[0] = 1'b1;
            cand[0]   = kl_pkg::mk_res(kl_pkg::K_ERR_LONG, st_i.line);
            st_p.mode = kl_pkg::M_HALT;
          end else begin
            for (int i = 0; i < 8; i++) begin
              if (3'(i) == st_i.word_len[2:0]) begin
                st_p.word[8*i +: 8] = char_i;
              end
            end
            st_p.word_len = st_i.word_len + 4'd1;
          end
        end else begin
          cand_v[0]     = 1'b1;
          cand[0]       = kl_pkg::word_res(st_i.word, st_i.word_len, st_i.line);
          st_p.word     = '0;
          st_p.word_len = '0;
          st_p.mode     = kl_pkg::M_IDLE;
          idle_path     = 1'b1;
        end
      end
      kl_pkg::M_NUMBER: begin
        if (is_digit) begin
          st_p.accum = (acc_wide > {4'b0, kl_pkg::INT_SAT}) ? kl_pkg::INT_SAT
                                                             : acc_wide[30:0];
        end else begin
          cand_v[0]    = 1'b1;
          cand[0]      = kl_pkg::mk_res(kl_pkg::K_INT, st_i.line);
          cand[0].ival = st_i.accum;
          st_p.accum   = '0;
          st_p.mode    = kl_pkg::M_IDLE;
          idle_path    = 1'b1;
        end
      end
      kl_pkg::M_SLASH: begin
        if (char_i == kl_pkg::CH_SLASH) begin
          st_p.mode = kl_pkg::M_LCOMMENT;
        end else if (char_i == kl_pkg::CH_STAR) begin
          st_p.mode = kl_pkg::M_BLOCK;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = kl_pkg::mk_res(kl_pkg::K_SLASH, st_i.line);
          st_p.mode = kl_pkg::M_IDLE;
          idle_path = 1'b1;
        end
      end
      kl_pkg::M_LCOMMENT: begin
        if (is_nl) begin
          st_p.mode = kl_pkg::M_IDLE;
        end
      end
      kl_pkg::M_BLOCK: begin
        if (char_i == kl_pkg::CH_STAR) begin
          st_p.mode = kl_pkg::M_BSTAR;
        end
      end
      kl_pkg::M_BSTAR: begin
        if (char_i == kl_pkg::CH_SLASH) begin
          st_p.mode = kl_pkg::M_IDLE;
        end else if (char_i != kl_pkg::CH_STAR) begin
          st_p.mode = kl_pkg::M_BLOCK;
        end
      end
      kl_pkg::M_HALT: begin
        st_p.mode = kl_pkg::M_HALT;
      end
      default: begin
        st_p.mode = kl_pkg::M_IDLE;
      end
    endcase

    // byte seen from idle: punctuation, whitespace, start of a token or an invalid byte
    if (idle_path) begin
      if (punct[5]) begin
        cand_v[1] = 1'b1;
        cand[1]   = kl_pkg::mk_res(punct[4:0], st_i.line);
      end else if (char_i == kl_pkg::CH_SLASH) begin
        st_p.mode = kl_pkg::M_SLASH;
      end else if (is_ws || is_nl) begin
        st_p.mode = kl_pkg::M_IDLE;
      end else if (is_alpha) begin
        st_p.mode     = kl_pkg::M_IDENT;
        st_p.word     = {56'b0, char_i};
        st_p.word_len = 4'd1;
      end else if (is_digit) begin
        st_p.mode  = kl_pkg::M_NUMBER;
        st_p.accum = {27'b0, dig_full[3:0]};
      end else begin
        cand_v[1] = 1'b1;
        cand[1]   = kl_pkg::mk_res(kl_pkg::K_ERR_BYTE, st_i.line);
        st_p.mode = kl_pkg::M_HALT;
      end
    end

    // end of text: flush what is pending, then end or open comment error
    st_o = st_p;
    if (last_i) begin
      unique case (st_p.mode)
        kl_pkg::M_IDENT: begin
          cand_v[3:2] = 2'b11;
          cand[2]     = kl_pkg::word_res(st_p.word, st_p.word_len, line_after);
          cand[3]     = kl_pkg::mk_res(kl_pkg::K_END, line_after);
        end
        kl_pkg::M_NUMBER: begin
          cand_v[3:2]  = 2'b11;
          cand[2]      = kl_pkg::mk_res(kl_pkg::K_INT, line_after);
          cand[2].ival = st_p.accum;
          cand[3]      = kl_pkg::mk_res(kl_pkg::K_END, line_after);
        end
        kl_pkg::M_SLASH: begin
          cand_v[3:2] = 2'b11;
          cand[2]     = kl_pkg::mk_res(kl_pkg::K_SLASH, line_after);
          cand[3]     = kl_pkg::mk_res(kl_pkg::K_END, line_after);
        end
        kl_pkg::M_BLOCK, kl_pkg::M_BSTAR: begin
          cand_v[2] = 1'b1;
          cand[2]   = kl_pkg::mk_res(kl_pkg::K_ERR_OPEN, line_after);
        end
        kl_pkg::M_HALT: begin
          cand_v[2] = 1'b0;
        end
        default: begin
          cand_v[2] = 1'b1;
          cand[2]   = kl_pkg::mk_res(kl_pkg::K_END, line_after);
        end
      endcase
      // a new text starts from the reset state
      st_o.mode     = kl_pkg::M_IDLE;
      st_o.word     = '0;
      st_o.word_len = '0;
      st_o.accum    = '0;
      st_o.line     = 16'd1;
    end

    // pack the present candidates in order
    res_o = '0;
    n     = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        if (n < 3'(kl_pkg::MAX_RES)) begin
          res_o[n[1:0]] = cand[k];
        end
        n = n + 3'd1;
      end
    end
    last_idx = n[1:0] - 2'd1;
    if (n != 3'd0) begin
      res_o[last_idx].last = 1'b1;
    end
    cnt_o = n[1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/keyword_lexer.sv =====
// keyword_lexer: top level with input register, lexer state and token queue
//
// Source bytes enter on in_char_code with in_last_in marking the final byte
// of a text; an in_ word is taken at a clock edge where in_valid is high and
// in_stall is low. Tokens leave on the out_ ports under out_valid/out_stall,
// one token per word, out_last_out set on the final token caused by a byte.
// A byte is lexed while it sits in the input register, and its tokens are
// loaded into the token queue as the byte leaves that register. One byte is
// taken every cycle while each byte yields at most one token and out_stall
// stays low; a byte that yields two or three tokens holds back the next byte
// until the queue is down to its final token and that token is taken, as the
// three-entry token queue drains one word a cycle while out_stall is low.
// A stall on the output side keeps the queued token steady and backs up into
// in_stall once the input register is full. Reset clears the queue, the
// input register and the lexer state (idle mode, line one); the block takes
// bytes from the first cycle after reset, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_src_line,
  output logic [30:0]      out_int_value,
  output logic [63:0]      out_ident_chars,
  output logic [3:0]       out_ident_length,
  output logic             out_last_out
);

  logic                                in_v_r;
  logic [7:0]                          in_char_r;
  logic                                in_last_r;
  kl_pkg::lex_state_t                  st_r;
  kl_pkg::lex_state_t                  st_nxt;
  kl_pkg::res_t [kl_pkg::MAX_RES-1:0]  step_res;
  logic [1:0]                          step_cnt;
  kl_pkg::res_t [kl_pkg::MAX_RES-1:0]  q_r;
  logic [1:0]                          q_cnt_r;
  logic [1:0]                          q_rd_r;
  kl_pkg::res_t                        head;
  logic                                pop;
  logic                                go;

  // lexer step on the registered byte
  kl_step u_step (
    .st_i   (st_r),
    .char_i (in_char_r),
    .last_i (in_last_r),
    .st_o   (st_nxt),
    .res_o  (step_res),
    .cnt_o  (step_cnt)
  );

  // handshake control
  assign pop      = out_valid && !out_stall;
  assign go       = in_v_r && (q_cnt_r == 2'd0 || (q_cnt_r == 2'd1 && pop));
  assign in_stall = in_v_r && !go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_code;
      in_last_r <= in_last_in;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= kl_pkg::M_IDLE;
      st_r.word     <= '0;
      st_r.word_len <= '0;
      st_r.accum    <= '0;
      st_r.line     <= 16'd1;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  // token queue: loaded with a whole batch, drained one word a cycle while out_stall is low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_rd_r  <= '0;
    end else if (go && step_cnt != 2'd0) begin
      q_cnt_r <= step_cnt;
      q_rd_r  <= '0;
    end else if (pop) begin
      q_cnt_r <= q_cnt_r - 2'd1;
      q_rd_r  <= q_rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go && step_cnt != 2'd0) begin
      q_r <= step_res;
    end
  end

  // output ports
  assign head             = q_r[q_rd_r];
  assign out_valid        = q_cnt_r != 2'd0;
  assign out_token_kind   = head.kind;
  assign out_src_line     = head.line;
  assign out_int_value    = head.ival;
  assign out_ident_chars  = head.chars;
  assign out_ident_length = head.len;
  assign out_last_out     = head.last;

  // queue never runs past its three entries
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, q_rd_r} + {1'b0, q_cnt_r}) <= 3'(kl_pkg::MAX_RES))
    else $error("token queue read pointer ran past its batch");

  // end-of-byte marker sits on the final queued token only
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_out |-> q_cnt_r == 2'd1)
    else $error("last_out shown before the final token of a byte");

  // the final byte of a text returns the lexer to its reset state
  a_text_reset: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_last_r |=> st_r.mode == kl_pkg::M_IDLE && st_r.line == 16'd1 &&
                        st_r.word_len == 4'd0)
    else $error("lexer state not cleared after end of text");

  // once halted the lexer produces nothing
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    go && st_r.mode == kl_pkg::M_HALT |-> step_cnt == 2'd0)
    else $error("token produced while halted");

endmodule

`default_nettype wire

// ===== tb/sv/keyword_lexer_tb.sv =====
// keyword_lexer_tb: randomised self-checking bench for the keyword lexer
`timescale 1ns / 1ps

module keyword_lexer_tb;
  import kl_pkg::*;

  // one source byte waiting to be offered, with its lead-in gap
  typedef struct {
    logic [7:0] code;
    logic       fin;
    int         gap;
    bit         drain;
  } src_byte_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_src_line;
  logic [30:0] out_int_value;
  logic [63:0] out_ident_chars;
  logic [3:0]  out_ident_length;
  logic        out_last_out;

  keyword_lexer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_src_line     (out_src_line),
    .out_int_value    (out_int_value),
    .out_ident_chars  (out_ident_chars),
    .out_ident_length (out_ident_length),
    .out_last_out     (out_last_out)
  );

  src_byte_t   src_bytes[$];
  res_t        tokens_due[$];
  res_t        step_toks[$];
  logic [7:0]  txt[$];

  // lexer shadow state
  lex_mode_t   lx_mode = M_IDLE;
  logic [63:0] lx_word = '0;
  logic [3:0]  lx_len = '0;
  logic [30:0] lx_accum = '0;
  logic [15:0] lx_line = 16'd1;

  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          rx_hold = 1'b0;
  int          rx_wait = 0;
  int          rx_level = 1;
  int          rx_count = 0;
  int          bytes_taken = 0;
  int          toks_seen = 0;
  int          texts_made = 0;
  int          mismatches = 0;
  logic [15:0] top_line = '0;
  logic [21:0] kinds_seen = '0;

  string kw_spell[6] = '{"exit", "let", "const", "if", "elif", "else"};
  string saturating[5] = '{"2147483647", "2147483648", "99999999999", "0", "007"};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // character classes
  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // idle gap draw: 0 none, 1 occasional, 2 heavy
  function automatic int pick_gap(input int level);
    if (level == 0) return 0;
    if (level == 1) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    return $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic emit_tok(input logic [4:0] kind, input logic [30:0] ival,
                          input logic [63:0] chars, input logic [3:0] len);
    res_t r;
    if (step_toks.size() < MAX_RES) begin
      r       = '0;
      r.kind  = kind;
      r.line  = lx_line;
      r.ival  = ival;
      r.chars = chars;
      r.len   = len;
      step_toks.push_back(r);
    end
  endtask

  task automatic bump_line();
    if (lx_line != LINE_SAT) lx_line = lx_line + 16'd1;
  endtask

  task automatic clear_lexer();
    lx_mode  = M_IDLE;
    lx_word  = '0;
    lx_len   = '0;
    lx_accum = '0;
    lx_line  = 16'd1;
  endtask

  // collected word becomes a keyword or an identifier
  task automatic flush_word();
    logic [4:0] kind;
    kind = K_IDENT;
    if (lx_len == 4'd4 && lx_word == KW_EXIT) kind = K_EXIT;
    if (lx_len == 4'd3 && lx_word == KW_LET) kind = K_LET;
    if (lx_len == 4'd5 && lx_word == KW_CONST) kind = K_CONST;
    if (lx_len == 4'd2 && lx_word == KW_IF) kind = K_IF;
    if (lx_len == 4'd4 && lx_word == KW_ELIF) kind = K_ELIF;
    if (lx_len == 4'd4 && lx_word == KW_ELSE) kind = K_ELSE;
    if (kind == K_IDENT) emit_tok(K_IDENT, '0, lx_word, lx_len);
    else emit_tok(kind, '0, '0, '0);
  endtask

  // byte seen with no token in progress
  task automatic idle_byte(input logic [7:0] c);
    case (c)
      CH_LPAREN: emit_tok(K_LPAREN, '0, '0, '0);
      CH_RPAREN: emit_tok(K_RPAREN, '0, '0, '0);
      CH_EQUAL:  emit_tok(K_EQUAL, '0, '0, '0);
      CH_PLUS:   emit_tok(K_PLUS, '0, '0, '0);
      CH_MINUS:  emit_tok(K_MINUS, '0, '0, '0);
      CH_STAR:   emit_tok(K_STAR, '0, '0, '0);
      CH_LBRACE: emit_tok(K_LBRACE, '0, '0, '0);
      CH_RBRACE: emit_tok(K_RBRACE, '0, '0, '0);
      CH_SEMI:   emit_tok(K_SEMI, '0, '0, '0);
      CH_SLASH:  lx_mode = M_SLASH;
      CH_NL:     bump_line();
      CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
      default: begin
        if (is_letter(c)) begin
          lx_mode = M_IDENT;
          lx_word = {56'd0, c};
          lx_len  = 4'd1;
        end else if (is_digit(c)) begin
          lx_mode  = M_NUMBER;
          lx_accum = {23'd0, c - CH_ZERO};
        end else begin
          emit_tok(K_ERR_BYTE, '0, '0, '0);
          lx_mode = M_HALT;
        end
      end
    endcase
  endtask

  // tokens caused by one accepted byte, queued as expectations
  task automatic lex_byte(input logic [7:0] c, input logic fin);
    logic [31:0] acc;
    logic [31:0] dig;
    step_toks.delete();
    acc = {1'b0, lx_accum};
    dig = {24'd0, c - CH_ZERO};
    if (lx_mode != M_HALT) begin
      case (lx_mode)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (lx_len >= IDENT_MAX) begin
              emit_tok(K_ERR_LONG, '0, '0, '0);
              lx_mode = M_HALT;
            end else begin
              lx_word[8*lx_len +: 8] = c;
              lx_len = lx_len + 4'd1;
            end
          end else begin
            flush_word();
            lx_word = '0;
            lx_len  = '0;
            lx_mode = M_IDLE;
            idle_byte(c);
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            if (acc > ({1'b0, INT_SAT} - dig) / 32'd10) lx_accum = INT_SAT;
            else lx_accum = 31'(acc * 32'd10 + dig);
          end else begin
            emit_tok(K_INT, lx_accum, '0, '0);
            lx_accum = '0;
            lx_mode  = M_IDLE;
            idle_byte(c);
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) lx_mode = M_LCOMMENT;
          else if (c == CH_STAR) lx_mode = M_BLOCK;
          else begin
            emit_tok(K_SLASH, '0, '0, '0);
            lx_mode = M_IDLE;
            idle_byte(c);
          end
        end
        M_LCOMMENT: begin
          if (c == CH_NL) begin
            lx_mode = M_IDLE;
            bump_line();
          end
        end
        M_BLOCK: begin
          if (c == CH_NL) bump_line();
          else if (c == CH_STAR) lx_mode = M_BSTAR;
        end
        M_BSTAR: begin
          if (c == CH_SLASH) lx_mode = M_IDLE;
          else if (c != CH_STAR) begin
            if (c == CH_NL) bump_line();
            lx_mode = M_BLOCK;
          end
        end
        default: begin
          lx_mode = M_IDLE;
          idle_byte(c);
        end
      endcase
    end
    // end of text: flush what is pending, then end or open-comment error
    if (fin) begin
      case (lx_mode)
        M_IDENT: begin
          flush_word();
          emit_tok(K_END, '0, '0, '0);
        end
        M_NUMBER: begin
          emit_tok(K_INT, lx_accum, '0, '0);
          emit_tok(K_END, '0, '0, '0);
        end
        M_SLASH: begin
          emit_tok(K_SLASH, '0, '0, '0);
          emit_tok(K_END, '0, '0, '0);
        end
        M_BLOCK, M_BSTAR: emit_tok(K_ERR_OPEN, '0, '0, '0);
        M_HALT: ;
        default: emit_tok(K_END, '0, '0, '0);
      endcase
      clear_lexer();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[k]) tokens_due.push_back(step_toks[k]);
  endtask

  // ---------------------------------------------------------------- text building

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(CH_LC_A, CH_LC_Z))
                                : 8'($urandom_range(CH_UC_A, CH_UC_Z));
  endfunction

  // comment body byte, biased towards star, slash and newline
  function automatic logic [7:0] comment_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return CH_STAR;
    if (sel < 3) return CH_NL;
    if (sel < 4) return CH_SLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  // byte that starts no token and is not whitespace
  function automatic logic [7:0] bad_byte();
    logic [7:0] c;
    bit ok;
    ok = 1'b0;
    c  = 8'h00;
    while (!ok) begin
      c = 8'($urandom_range(0, 255));
      ok = !is_letter(c) && !is_digit(c);
      case (c)
        CH_LPAREN, CH_RPAREN, CH_EQUAL, CH_PLUS, CH_MINUS, CH_STAR, CH_LBRACE,
        CH_RBRACE, CH_SEMI, CH_SLASH, CH_NL, CH_SPACE, CH_TAB, CH_VT, CH_FF,
        CH_CR: ok = 1'b0;
        default: ;
      endcase
    end
    return c;
  endfunction

  // one random lexical piece appended to the text under construction
  task automatic add_piece();
    int sel;
    int n;
    int i;
    string punct;
    string blanks;
    punct  = "()=+-*{};/";
    blanks = " \t\n\n\v\f\r";
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      add_str(kw_spell[$urandom_range(0, 5)]);
    end else if (sel < 32) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
      txt.push_back(rand_letter());
      for (i = 1; i < n; i++)
        txt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(CH_ZERO, CH_NINE))
                                                  : rand_letter());
    end else if (sel < 45) begin
      if ($urandom_range(0, 5) == 0) add_str(saturating[$urandom_range(0, 4)]);
      else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) txt.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
    end else if (sel < 63) begin
      txt.push_back(punct[$urandom_range(0, punct.len() - 1)]);
    end else if (sel < 82) begin
      txt.push_back(blanks[$urandom_range(0, blanks.len() - 1)]);
    end else if (sel < 88) begin
      add_str("//");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) txt.push_back(8'($urandom_range(0, 255)));
      txt.push_back(CH_NL);
    end else if (sel < 96) begin
      add_str("/*");
      n = $urandom_range(0, 7);
      for (i = 0; i < n; i++) txt.push_back(comment_byte());
      add_str("*/");
    end else begin
      txt.push_back(bad_byte());
    end
  endtask

  // move the built text into the offer queue, last flag on its final byte
  task automatic commit_text(input int level, input bit drain);
    src_byte_t b;
    int i;
    for (i = 0; i < txt.size(); i++) begin
      b.code  = txt[i];
      b.fin   = (i == txt.size() - 1);
      b.gap   = pick_gap(level);
      b.drain = drain && (i == 0);
      src_bytes.push_back(b);
    end
    txt.delete();
    texts_made++;
  endtask

  // ---------------------------------------------------------------- sender

  // offers the next word once the current one is taken and its gap has run out
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // stalled word stays as it is
      end else if (src_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (src_bytes[0].drain && tokens_due.size() != 0) begin
        in_valid <= 1'b0;
      end else if (src_bytes[0].gap > 0) begin
        src_bytes[0].gap = src_bytes[0].gap - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid     <= 1'b1;
        in_char_code <= src_bytes[0].code;
        in_last_in   <= src_bytes[0].fin;
        void'(src_bytes.pop_front());
      end
      in_fire = 1'b0;
    end
  end

  // ---------------------------------------------------------------- receiver

  // per-word stall draw, level changed every few dozen tokens
  always @(negedge clk) begin
    if (out_fire) begin
      out_fire = 1'b0;
      rx_count++;
      if (rx_count % 40 == 0) rx_level = $urandom_range(0, 2);
      rx_wait = pick_gap(rx_level);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
    out_stall <= rx_hold || (rx_wait != 0);
  end

  // one long hold-off so the token queue fills and backs up into the input
  initial begin
    wait (bytes_taken >= 150);
    rx_hold = 1'b1;
    repeat (250) @(negedge clk);
    rx_hold = 1'b0;
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------- monitor

  // input words feed the predictor, output words are compared in order
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        lex_byte(in_char_code, in_last_in);
        in_fire = 1'b1;
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        out_fire = 1'b1;
        toks_seen++;
        if (out_token_kind <= K_ERR_OPEN) kinds_seen[out_token_kind] = 1'b1;
        if (out_src_line > top_line) top_line = out_src_line;
        if (tokens_due.size() == 0) begin
          $error("token kind %0d line %0d arrived with none outstanding",
                 out_token_kind, out_src_line);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 64'(want.kind), 64'(out_token_kind));
          check_field("src_line", 64'(want.line), 64'(out_src_line));
          check_field("int_value", 64'(want.ival), 64'(out_int_value));
          check_field("ident_chars", want.chars, out_ident_chars);
          check_field("ident_length", 64'(want.len), 64'(out_ident_length));
          check_field("last_out", 64'(want.last), 64'(out_last_out));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int n;
    int i;
    // directed: mixed tokens ending on three results from one byte
    add_str("elif(9a/)");
    commit_text(1, 1'b0);
    // block comment spanning a newline
    add_str("/*\n*/");
    commit_text(1, 1'b0);
    // zero byte as the whole text
    txt.push_back(8'h00);
    commit_text(1, 1'b0);
    // top byte value halts the text, remaining bytes dropped
    add_str("=");
    txt.push_back(8'hFF);
    add_str("q");
    commit_text(1, 1'b0);
    // comment still open at the end
    add_str("/*");
    commit_text(0, 1'b0);
    // long identifier right after a keyword
    add_str("let abcdefghi");
    commit_text(0, 1'b1);

    // random texts built from well-formed pieces with some noise
    while (src_bytes.size() < 345) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) add_piece();
      if ($urandom_range(0, 14) == 0) begin
        add_str("/*");
        txt.push_back(comment_byte());
      end
      commit_text($urandom_range(0, 2), (texts_made % 8) == 0);
    end

    // closing text after a pause: newlines in and out of a comment, integer last
    add_str("a\n\n/*\n*/9");
    commit_text(0, 1'b1);

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain everything, then allow the pipeline to settle
    while (src_bytes.size() != 0 || in_valid || tokens_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("lexed %0d bytes over %0d texts, %0d tokens compared",
             bytes_taken, texts_made, toks_seen);
    $display("%0d of 22 token kinds seen, highest line number %0d",
             $countones(kinds_seen), top_line);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
